// File: rtl/tvbb_pkg.sv
// Package with the word types, register indexes and constants of the transformed vertex bounding box.
`default_nettype none

package tvbb_pkg;

	localparam int unsigned CoordW  = 32;
	localparam int unsigned CfgIdxW = 4;
	localparam int unsigned ProdW   = 2 * CoordW;
	localparam int unsigned SumW    = ProdW + 2;

	// Configuration register indexes.
	localparam logic [CfgIdxW-1:0] CFG_ROW_X_COEF_X = 4'd0;
	localparam logic [CfgIdxW-1:0] CFG_ROW_X_COEF_Y = 4'd1;
	localparam logic [CfgIdxW-1:0] CFG_ROW_X_COEF_Z = 4'd2;
	localparam logic [CfgIdxW-1:0] CFG_ROW_X_OFFSET = 4'd3;
	localparam logic [CfgIdxW-1:0] CFG_ROW_Y_COEF_X = 4'd4;
	localparam logic [CfgIdxW-1:0] CFG_ROW_Y_COEF_Y = 4'd5;
	localparam logic [CfgIdxW-1:0] CFG_ROW_Y_COEF_Z = 4'd6;
	localparam logic [CfgIdxW-1:0] CFG_ROW_Y_OFFSET = 4'd7;

	localparam logic signed [CoordW-1:0] Q16_ONE   = 32'sh0001_0000;
	localparam logic signed [CoordW-1:0] Q16_ZERO  = 32'sh0000_0000;
	localparam logic signed [CoordW-1:0] COORD_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [CoordW-1:0] COORD_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic signed [CoordW-1:0] vertex_x;
		logic signed [CoordW-1:0] vertex_y;
		logic signed [CoordW-1:0] vertex_z;
		logic                     last_vertex;
	} vertex_t;

	typedef struct packed {
		logic signed [CoordW-1:0] box_left;
		logic signed [CoordW-1:0] box_bottom;
		logic        [CoordW-1:0] box_width;
		logic        [CoordW-1:0] box_height;
		logic                     box_empty;
	} box_t;

	typedef struct packed {
		logic signed [CoordW-1:0] coef_x;
		logic signed [CoordW-1:0] coef_y;
		logic signed [CoordW-1:0] coef_z;
		logic signed [CoordW-1:0] offset;
	} coef_row_t;

	typedef struct packed {
		logic signed [CoordW-1:0] screen_x;
		logic signed [CoordW-1:0] screen_y;
		logic                     last;
	} screen_t;

endpackage

`default_nettype wire

// File: rtl/transformed_vertex_bounding_box_top.sv
// Top level of the transformed vertex bounding box: configuration, running extremes, result word.
//
//  channel | direction | handshake              | word
//  --------+-----------+------------------------+-------------------------------------
//  in      | input     | in_valid / in_ready    | tvbb_pkg::vertex_t (x, y, z, last)
//  out     | output    | out_valid / out_ready  | tvbb_pkg::box_t (corner, size, empty)
//  cfg     | input     | cfg_valid / cfg_ready  | cfg_index (4 bits), cfg_data (32 bits)
//
// One vertex word is accepted every cycle unless a held last vertex stalls the stages; the
// transform takes three register stages (input, six 32x32 products, sum with floor and
// saturation), and the box word of a mesh is registered as its last vertex leaves them.
// Reset sets the matrix to identity in x and y and clears the running extremes.
// While a box word waits, vertices that are not last keep flowing; a last vertex holds in
// the final transform stage until the output register is free, and the stages behind it fill.
// cfg_ready is always high; a write with an index of eight or above is dropped.
`default_nettype none

module transformed_vertex_bounding_box_top (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire tvbb_pkg::vertex_t                     in_data,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output tvbb_pkg::box_t                             out_data,
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic [tvbb_pkg::CfgIdxW-1:0]          cfg_index,
	input  wire logic [tvbb_pkg::CoordW-1:0]           cfg_data
);

	localparam int unsigned W = tvbb_pkg::CoordW;

	// Matrix rows for screen x and screen y.
	tvbb_pkg::coef_row_t row_x_q, row_y_q;

	// Transform output toward the accumulator.
	logic              scr_valid, scr_ready;
	tvbb_pkg::screen_t scr;

	// Running extremes of the counted vertices of the current mesh.
	logic signed [W-1:0] least_x_q, greatest_x_q, least_y_q, greatest_y_q;
	logic                any_q;

	logic signed [W-1:0] least_x_n, greatest_x_n, least_y_n, greatest_y_n;
	logic                any_n, counted, scr_fire;

	logic           out_valid_q;
	tvbb_pkg::box_t out_q;

	assign cfg_ready = 1'b1;

	// Configuration writes; the user writes registers only while the block is idle (not enforced).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_x_q.coef_x <= tvbb_pkg::Q16_ONE;
			row_x_q.coef_y <= tvbb_pkg::Q16_ZERO;
			row_x_q.coef_z <= tvbb_pkg::Q16_ZERO;
			row_x_q.offset <= tvbb_pkg::Q16_ZERO;
			row_y_q.coef_x <= tvbb_pkg::Q16_ZERO;
			row_y_q.coef_y <= tvbb_pkg::Q16_ONE;
			row_y_q.coef_z <= tvbb_pkg::Q16_ZERO;
			row_y_q.offset <= tvbb_pkg::Q16_ZERO;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				tvbb_pkg::CFG_ROW_X_COEF_X: row_x_q.coef_x <= cfg_data;
				tvbb_pkg::CFG_ROW_X_COEF_Y: row_x_q.coef_y <= cfg_data;
				tvbb_pkg::CFG_ROW_X_COEF_Z: row_x_q.coef_z <= cfg_data;
				tvbb_pkg::CFG_ROW_X_OFFSET: row_x_q.offset <= cfg_data;
				tvbb_pkg::CFG_ROW_Y_COEF_X: row_y_q.coef_x <= cfg_data;
				tvbb_pkg::CFG_ROW_Y_COEF_Y: row_y_q.coef_y <= cfg_data;
				tvbb_pkg::CFG_ROW_Y_COEF_Z: row_y_q.coef_z <= cfg_data;
				tvbb_pkg::CFG_ROW_Y_OFFSET: row_y_q.offset <= cfg_data;
				default: ;
			endcase
		end
	end

	tvbb_xform u_xform (
		.clk       (clk),
		.arst_n    (arst_n),
		.row_x     (row_x_q),
		.row_y     (row_y_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (scr_valid),
		.out_ready (scr_ready),
		.out_data  (scr)
	);

	// Only a last vertex needs the output register, so only it can be held back.
	assign scr_ready = !scr.last || !out_valid_q || out_ready;
	assign scr_fire  = scr_valid && scr_ready;

	// A vertex counts unless its screen x or screen y is exactly zero.
	always_comb begin
		counted      = (scr.screen_x != tvbb_pkg::Q16_ZERO) && (scr.screen_y != tvbb_pkg::Q16_ZERO);
		least_x_n    = (counted && scr.screen_x < least_x_q)    ? scr.screen_x : least_x_q;
		greatest_x_n = (counted && scr.screen_x > greatest_x_q) ? scr.screen_x : greatest_x_q;
		least_y_n    = (counted && scr.screen_y < least_y_q)    ? scr.screen_y : least_y_q;
		greatest_y_n = (counted && scr.screen_y > greatest_y_q) ? scr.screen_y : greatest_y_q;
		any_n        = any_q || counted;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			least_x_q    <= tvbb_pkg::COORD_MAX;
			greatest_x_q <= tvbb_pkg::COORD_MIN;
			least_y_q    <= tvbb_pkg::COORD_MAX;
			greatest_y_q <= tvbb_pkg::COORD_MIN;
			any_q        <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			// A new box word takes the output register; otherwise a taken word leaves it.
			if (scr_fire && scr.last) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (scr_fire) begin
				if (scr.last) begin
					// The mesh ends here: start the next one from the reset extremes.
					least_x_q    <= tvbb_pkg::COORD_MAX;
					greatest_x_q <= tvbb_pkg::COORD_MIN;
					least_y_q    <= tvbb_pkg::COORD_MAX;
					greatest_y_q <= tvbb_pkg::COORD_MIN;
					any_q        <= 1'b0;
				end else begin
					least_x_q    <= least_x_n;
					greatest_x_q <= greatest_x_n;
					least_y_q    <= least_y_n;
					greatest_y_q <= greatest_y_n;
					any_q        <= any_n;
				end
			end
		end
	end

	// The box word includes the last vertex itself; an empty mesh gives zero fields with box_empty set.
	always_ff @(posedge clk) begin
		if (scr_fire && scr.last) begin
			if (any_n) begin
				out_q.box_left   <= least_x_n;
				out_q.box_bottom <= least_y_n;
				out_q.box_width  <= greatest_x_n - least_x_n;
				out_q.box_height <= greatest_y_n - least_y_n;
				out_q.box_empty  <= 1'b0;
			end else begin
				out_q.box_left   <= tvbb_pkg::Q16_ZERO;
				out_q.box_bottom <= tvbb_pkg::Q16_ZERO;
				out_q.box_width  <= '0;
				out_q.box_height <= '0;
				out_q.box_empty  <= 1'b1;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// After a last vertex nothing is counted and least x and greatest y are at their reset values.
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(scr_fire && scr.last) |=> (!any_q && least_x_q == tvbb_pkg::COORD_MAX
			&& greatest_y_q == tvbb_pkg::COORD_MIN))
		else $error("extremes not cleared after last vertex");

	// Once a vertex has counted, the extremes form a proper interval.
	a_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		any_q |-> (least_x_q <= greatest_x_q && least_y_q <= greatest_y_q))
		else $error("running minimum above running maximum");

	// With nothing counted the extremes still hold their reset values.
	a_untouched: assert property (@(posedge clk) disable iff (!arst_n)
		!any_q |-> (least_x_q == tvbb_pkg::COORD_MAX && greatest_x_q == tvbb_pkg::COORD_MIN
			&& least_y_q == tvbb_pkg::COORD_MAX && greatest_y_q == tvbb_pkg::COORD_MIN))
		else $error("extremes moved with no counted vertex");

	// A held box word must not be overwritten by the next last vertex.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !(scr_fire && scr.last))
		else $error("box word overwritten while waiting");

endmodule

`default_nettype wire

// File: rtl/tvbb_xform.sv
// Three-stage affine transform of one vertex to saturated screen x and y.
`default_nettype none

module tvbb_xform (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire tvbb_pkg::coef_row_t row_x,
	input  wire tvbb_pkg::coef_row_t row_y,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire tvbb_pkg::vertex_t   in_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output tvbb_pkg::screen_t        out_data
);

	localparam int unsigned W  = tvbb_pkg::CoordW;
	localparam int unsigned PW = tvbb_pkg::ProdW;
	localparam int unsigned SW = tvbb_pkg::SumW;

	logic valid_s1, valid_s2, valid_s3;
	logic adv_s1, adv_s2, adv_s3;

	tvbb_pkg::vertex_t vtx_s1;

	logic signed [PW-1:0] px_x_s2, px_y_s2, px_z_s2;
	logic signed [PW-1:0] py_x_s2, py_y_s2, py_z_s2;
	logic                 last_s2;

	tvbb_pkg::screen_t scr_s3;

	logic signed [SW-1:0] sum_x, sum_y;
	logic signed [W-1:0]  sat_x, sat_y;

	// Each stage moves when it is empty or the next one takes its word.
	assign adv_s3   = !valid_s3 || out_ready;
	assign adv_s2   = !valid_s2 || adv_s3;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_ready = adv_s1;

	function automatic logic signed [SW-1:0] row_sum(
		input logic signed [PW-1:0] p0,
		input logic signed [PW-1:0] p1,
		input logic signed [PW-1:0] p2,
		input logic signed [W-1:0]  off
	);
		logic signed [SW-1:0] off_w;
		off_w = {{(SW-W-16){off[W-1]}}, off, 16'b0};
		return {{(SW-PW){p0[PW-1]}}, p0} + {{(SW-PW){p1[PW-1]}}, p1}
			+ {{(SW-PW){p2[PW-1]}}, p2} + off_w;
	endfunction

	// Floor shift by 16, then clamp to the signed 32-bit range.
	function automatic logic signed [W-1:0] floor_sat(input logic signed [SW-1:0] s);
		logic [SW-16-W:0] top_bits;
		top_bits = s[SW-1:W+15];
		if ((&top_bits) || !(|top_bits)) begin
			return s[W+15:16];
		end else if (s[SW-1]) begin
			return tvbb_pkg::COORD_MIN;
		end else begin
			return tvbb_pkg::COORD_MAX;
		end
	endfunction

	always_comb begin
		sum_x = row_sum(px_x_s2, px_y_s2, px_z_s2, row_x.offset);
		sum_y = row_sum(py_x_s2, py_y_s2, py_z_s2, row_y.offset);
		sat_x = floor_sat(sum_x);
		sat_y = floor_sat(sum_y);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= in_valid;
			if (adv_s2) valid_s2 <= valid_s1;
			if (adv_s3) valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			vtx_s1 <= in_data;
		end
		if (adv_s2 && valid_s1) begin
			px_x_s2 <= row_x.coef_x * vtx_s1.vertex_x;
			px_y_s2 <= row_x.coef_y * vtx_s1.vertex_y;
			px_z_s2 <= row_x.coef_z * vtx_s1.vertex_z;
			py_x_s2 <= row_y.coef_x * vtx_s1.vertex_x;
			py_y_s2 <= row_y.coef_y * vtx_s1.vertex_y;
			py_z_s2 <= row_y.coef_z * vtx_s1.vertex_z;
			last_s2 <= vtx_s1.last_vertex;
		end
		if (adv_s3 && valid_s2) begin
			scr_s3.screen_x <= sat_x;
			scr_s3.screen_y <= sat_y;
			scr_s3.last     <= last_s2;
		end
	end

	assign out_valid = valid_s3;
	assign out_data  = scr_s3;

endmodule

`default_nettype wire

// File: sim/transformed_vertex_bounding_box_top_tb.sv
// Self-checking testbench for the transformed vertex bounding box, with its own box predictor.
`default_nettype none

module transformed_vertex_bounding_box_top_tb;

	timeunit 1ns;
	timeprecision 1ps;

	// The accumulator is wide enough for three full 32x32 products plus the shifted offset.
	localparam int unsigned AccW        = tvbb_pkg::SumW + 2;
	localparam int unsigned DrainCycles = 12;
	localparam int unsigned BlockWords  = 135;

	logic                             clk;
	logic                             arst_n    = 1'b0;
	logic                             in_valid  = 1'b0;
	logic                             in_ready;
	tvbb_pkg::vertex_t                in_data   = '0;
	logic                             out_valid;
	logic                             out_ready = 1'b0;
	tvbb_pkg::box_t                   out_data;
	logic                             cfg_valid = 1'b0;
	logic                             cfg_ready;
	logic [tvbb_pkg::CfgIdxW-1:0]     cfg_index = '0;
	logic [tvbb_pkg::CoordW-1:0]      cfg_data  = '0;

	transformed_vertex_bounding_box_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Vertex words waiting to be sent, and the box words the meshes sent so far must produce.
	tvbb_pkg::vertex_t pending_vertices[$];
	tvbb_pkg::box_t    expected_boxes[$];

	// Our copy of the matrix rows and of the running extremes of the current mesh.
	tvbb_pkg::coef_row_t                matrix_row_x;
	tvbb_pkg::coef_row_t                matrix_row_y;
	logic signed [tvbb_pkg::CoordW-1:0] box_lo_x;
	logic signed [tvbb_pkg::CoordW-1:0] box_hi_x;
	logic signed [tvbb_pkg::CoordW-1:0] box_lo_y;
	logic signed [tvbb_pkg::CoordW-1:0] box_hi_y;
	logic                               box_counted;

	int unsigned vertices_sent  = 0;
	int unsigned vertices_taken = 0;
	int unsigned error_count    = 0;
	int unsigned send_idle_pct  = 18;
	int unsigned recv_idle_pct  = 53;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Hard stop in case the block hangs or drops a box word.
	initial begin
		#2_000_000;
		$display("TEST FAILED");
		$finish;
	end

	task automatic report_mismatch(input string what);
		error_count++;
		$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	// Empty box state: extremes at the opposite ends of the range, nothing counted.
	function automatic void clear_extremes();
		box_lo_x    = tvbb_pkg::COORD_MAX;
		box_hi_x    = tvbb_pkg::COORD_MIN;
		box_lo_y    = tvbb_pkg::COORD_MAX;
		box_hi_y    = tvbb_pkg::COORD_MIN;
		box_counted = 1'b0;
	endfunction

	// One row of the affine transform: the exact sum of the three products and the offset
	// (moved up by 16 fraction bits) is floored back to Q16.16 by the arithmetic shift,
	// then clamped to the signed 32-bit range.
	function automatic logic signed [tvbb_pkg::CoordW-1:0] project_axis(
		input tvbb_pkg::coef_row_t row,
		input tvbb_pkg::vertex_t   v
	);
		logic signed [AccW-1:0] wx, wy, wz, wo, px, py, pz, acc, hi_lim, lo_lim;
		wx     = AccW'(row.coef_x);
		wy     = AccW'(row.coef_y);
		wz     = AccW'(row.coef_z);
		wo     = AccW'(row.offset);
		px     = AccW'(v.vertex_x);
		py     = AccW'(v.vertex_y);
		pz     = AccW'(v.vertex_z);
		hi_lim = AccW'(tvbb_pkg::COORD_MAX);
		lo_lim = AccW'(tvbb_pkg::COORD_MIN);
		acc    = wx * px + wy * py + wz * pz + (wo <<< 16);
		acc    = acc >>> 16;
		if (acc > hi_lim)
			return tvbb_pkg::COORD_MAX;
		if (acc < lo_lim)
			return tvbb_pkg::COORD_MIN;
		return acc[tvbb_pkg::CoordW-1:0];
	endfunction

	// Called once per accepted vertex word. A vertex that lands exactly on either screen
	// axis is left out of the box. The last vertex of a mesh is folded in first, then the
	// box word is queued and the extremes start over.
	function automatic void track_vertex(input tvbb_pkg::vertex_t v);
		logic signed [tvbb_pkg::CoordW-1:0] sx, sy;
		tvbb_pkg::box_t                     b;
		sx = project_axis(matrix_row_x, v);
		sy = project_axis(matrix_row_y, v);
		if (sx != 0 && sy != 0) begin
			if (sx < box_lo_x) box_lo_x = sx;
			if (sx > box_hi_x) box_hi_x = sx;
			if (sy < box_lo_y) box_lo_y = sy;
			if (sy > box_hi_y) box_hi_y = sy;
			box_counted = 1'b1;
		end
		if (v.last_vertex) begin
			b = '0;
			if (box_counted) begin
				b.box_left   = box_lo_x;
				b.box_bottom = box_lo_y;
				b.box_width  = box_hi_x - box_lo_x;
				b.box_height = box_hi_y - box_lo_y;
			end else begin
				b.box_empty = 1'b1;
			end
			expected_boxes.insert(expected_boxes.size(), b);
			clear_extremes();
		end
	endfunction

	// Mirror of a register write; indexes past the last register leave the matrix alone.
	function automatic void store_reg(input logic [tvbb_pkg::CfgIdxW-1:0] idx,
					  input logic [tvbb_pkg::CoordW-1:0] value);
		case (idx)
			tvbb_pkg::CFG_ROW_X_COEF_X: matrix_row_x.coef_x = value;
			tvbb_pkg::CFG_ROW_X_COEF_Y: matrix_row_x.coef_y = value;
			tvbb_pkg::CFG_ROW_X_COEF_Z: matrix_row_x.coef_z = value;
			tvbb_pkg::CFG_ROW_X_OFFSET: matrix_row_x.offset = value;
			tvbb_pkg::CFG_ROW_Y_COEF_X: matrix_row_y.coef_x = value;
			tvbb_pkg::CFG_ROW_Y_COEF_Y: matrix_row_y.coef_y = value;
			tvbb_pkg::CFG_ROW_Y_COEF_Z: matrix_row_y.coef_z = value;
			tvbb_pkg::CFG_ROW_Y_OFFSET: matrix_row_y.offset = value;
			default: ;
		endcase
	endfunction

	// Sender: a word stays on the bus until taken; a new one goes out, or the bus idles,
	// only once the previous word has been taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				track_vertex(in_data);
				vertices_taken++;
			end
			if (!in_valid || in_ready) begin
				if (pending_vertices.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					in_data  <= pending_vertices.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks each box word taken against the oldest mesh still owed a box.
	always @(posedge clk or negedge arst_n) begin
		tvbb_pkg::box_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_boxes.size() == 0) begin
					report_mismatch("box word with no finished mesh waiting");
				end else begin
					want = expected_boxes.pop_front();
					if (out_data.box_left !== want.box_left)
						report_mismatch($sformatf("box_left %0h, want %0h",
							out_data.box_left, want.box_left));
					if (out_data.box_bottom !== want.box_bottom)
						report_mismatch($sformatf("box_bottom %0h, want %0h",
							out_data.box_bottom, want.box_bottom));
					if (out_data.box_width !== want.box_width)
						report_mismatch($sformatf("box_width %0h, want %0h",
							out_data.box_width, want.box_width));
					if (out_data.box_height !== want.box_height)
						report_mismatch($sformatf("box_height %0h, want %0h",
							out_data.box_height, want.box_height));
					if (out_data.box_empty !== want.box_empty)
						report_mismatch($sformatf("box_empty %0b, want %0b",
							out_data.box_empty, want.box_empty));
				end
			end
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Holds off until every queued vertex is taken and every box word has come back, then
	// lets the transform stages run dry so that a register write cannot meet a vertex in flight.
	task automatic wait_idle();
		while (vertices_taken != vertices_sent || expected_boxes.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_reg(input logic [tvbb_pkg::CfgIdxW-1:0] idx,
				 input logic [tvbb_pkg::CoordW-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		store_reg(idx, value);
		cfg_valid <= 1'b0;
	endtask

	// Loads both rows, then sends one stray write to an index past the register file.
	task automatic load_matrix(input tvbb_pkg::coef_row_t rx, input tvbb_pkg::coef_row_t ry);
		write_reg(tvbb_pkg::CFG_ROW_X_COEF_X, rx.coef_x);
		write_reg(tvbb_pkg::CFG_ROW_X_COEF_Y, rx.coef_y);
		write_reg(tvbb_pkg::CFG_ROW_X_COEF_Z, rx.coef_z);
		write_reg(tvbb_pkg::CFG_ROW_X_OFFSET, rx.offset);
		write_reg(tvbb_pkg::CFG_ROW_Y_COEF_X, ry.coef_x);
		write_reg(tvbb_pkg::CFG_ROW_Y_COEF_Y, ry.coef_y);
		write_reg(tvbb_pkg::CFG_ROW_Y_COEF_Z, ry.coef_z);
		write_reg(tvbb_pkg::CFG_ROW_Y_OFFSET, ry.offset);
		write_reg(tvbb_pkg::CfgIdxW'($urandom_range(8, 15)), $urandom);
	endtask

	task automatic send_vertex(input logic [tvbb_pkg::CoordW-1:0] x,
				   input logic [tvbb_pkg::CoordW-1:0] y,
				   input logic [tvbb_pkg::CoordW-1:0] z, input logic last);
		tvbb_pkg::vertex_t v;
		v.vertex_x    = x;
		v.vertex_y    = y;
		v.vertex_z    = z;
		v.last_vertex = last;
		pending_vertices.insert(pending_vertices.size(), v);
		vertices_sent++;
	endtask

	// Coordinates lean toward small values so that most boxes stay clear of saturation,
	// with zero and both range ends mixed in.
	function automatic logic [tvbb_pkg::CoordW-1:0] rand_coord();
		case ($urandom_range(9)) inside
			0:       return '0;
			1:       return tvbb_pkg::COORD_MAX;
			2:       return tvbb_pkg::COORD_MIN;
			[3:6]:   return tvbb_pkg::CoordW'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
			[7:8]:   return tvbb_pkg::CoordW'($urandom_range(0, 512)) - 32'd256;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [tvbb_pkg::CoordW-1:0] rand_weight();
		case ($urandom_range(11)) inside
			[0:1]:   return '0;
			2:       return tvbb_pkg::COORD_MAX;
			3:       return tvbb_pkg::COORD_MIN;
			[4:5]:   return tvbb_pkg::Q16_ONE;
			6:       return -tvbb_pkg::Q16_ONE;
			[7:9]:   return tvbb_pkg::CoordW'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
			10:      return tvbb_pkg::CoordW'($urandom_range(0, 512)) - 32'd256;
			default: return $urandom;
		endcase
	endfunction

	function automatic tvbb_pkg::coef_row_t rand_row();
		tvbb_pkg::coef_row_t r;
		r.coef_x = rand_weight();
		r.coef_y = rand_weight();
		r.coef_z = rand_weight();
		r.offset = ($urandom_range(2) == 0) ? tvbb_pkg::Q16_ZERO : rand_weight();
		return r;
	endfunction

	task automatic send_mesh(input int unsigned len, input bit blank);
		int unsigned k;
		for (k = 0; k < len; k++) begin
			if (blank)
				send_vertex('0, '0, '0, k == len - 1);
			else
				send_vertex(rand_coord(), rand_coord(), rand_coord(), k == len - 1);
		end
	endtask

	initial begin
		tvbb_pkg::coef_row_t rx, ry;
		int unsigned         phase, blk, sent_here, len;

		matrix_row_x = '{coef_x: tvbb_pkg::Q16_ONE, coef_y: tvbb_pkg::Q16_ZERO,
				 coef_z: tvbb_pkg::Q16_ZERO, offset: tvbb_pkg::Q16_ZERO};
		matrix_row_y = '{coef_x: tvbb_pkg::Q16_ZERO, coef_y: tvbb_pkg::Q16_ONE,
				 coef_z: tvbb_pkg::Q16_ZERO, offset: tvbb_pkg::Q16_ZERO};
		clear_extremes();

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed part, first on the identity matrix that reset leaves behind.
		// A lone vertex at the origin gives an empty box.
		send_vertex('0, '0, '0, 1'b1);
		// Vertices on either axis are dropped, so this mesh is empty too.
		send_vertex('0, tvbb_pkg::Q16_ONE, tvbb_pkg::Q16_ONE, 1'b0);
		send_vertex(tvbb_pkg::Q16_ONE, '0, tvbb_pkg::COORD_MAX, 1'b1);
		// Both ends of the coordinate range: the width and height wrap to all ones.
		send_vertex(tvbb_pkg::COORD_MAX, tvbb_pkg::COORD_MIN, '0, 1'b0);
		send_vertex(tvbb_pkg::COORD_MIN, tvbb_pkg::COORD_MAX, tvbb_pkg::COORD_MAX, 1'b0);
		send_vertex(32'd1, 32'hFFFF_FFFF, tvbb_pkg::COORD_MIN, 1'b1);
		// A single counted vertex gives a box of zero size.
		send_vertex(32'hFFFF_FFFF, 32'd1, 32'd5, 1'b1);
		wait_idle();

		// Full-scale weights: the nonzero vertices push the sums into saturation.
		rx = '{coef_x: tvbb_pkg::COORD_MAX, coef_y: tvbb_pkg::COORD_MAX,
		       coef_z: tvbb_pkg::COORD_MAX, offset: tvbb_pkg::COORD_MAX};
		ry = '{coef_x: tvbb_pkg::COORD_MIN, coef_y: tvbb_pkg::COORD_MIN,
		       coef_z: tvbb_pkg::COORD_MIN, offset: tvbb_pkg::COORD_MIN};
		load_matrix(rx, ry);
		send_vertex(tvbb_pkg::COORD_MAX, tvbb_pkg::COORD_MAX, tvbb_pkg::COORD_MAX, 1'b0);
		send_vertex(tvbb_pkg::COORD_MIN, tvbb_pkg::COORD_MIN, tvbb_pkg::COORD_MIN, 1'b0);
		send_vertex('0, '0, '0, 1'b1);
		send_vertex(32'd1, 32'hFFFF_FFFF, 32'd1, 1'b1);
		wait_idle();

		// Tiny weights show the floor: a fraction just below one maps to zero and is dropped,
		// while a fraction just below zero rounds down to minus one.
		rx = '{coef_x: 32'd1, coef_y: tvbb_pkg::Q16_ZERO, coef_z: tvbb_pkg::Q16_ZERO,
		       offset: tvbb_pkg::Q16_ZERO};
		ry = '{coef_x: tvbb_pkg::Q16_ZERO, coef_y: 32'hFFFF_FFFF, coef_z: tvbb_pkg::Q16_ONE,
		       offset: 32'hFFFF_FFFF};
		load_matrix(rx, ry);
		send_vertex(32'h0000_FFFF, 32'd5, '0, 1'b0);
		send_vertex(32'hFFFF_FFFF, '0, '0, 1'b0);
		send_vertex(32'h0002_0000, tvbb_pkg::Q16_ONE, 32'd3, 1'b1);
		send_vertex(32'hFFFF_0001, 32'h0001_0001, 32'h7FFF_0000, 1'b1);

		// Random meshes in three idling phases, a fresh matrix for each block of words.
		// The last block goes back to the reset matrix.
		for (phase = 0; phase < 3; phase++) begin
			wait_idle();
			case (phase)
				0: begin send_idle_pct = 18; recv_idle_pct = 53; end
				1: begin send_idle_pct = 53; recv_idle_pct = 18; end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			for (blk = 0; blk < 4; blk++) begin
				wait_idle();
				if (phase == 2 && blk == 3) begin
					rx = '{coef_x: tvbb_pkg::Q16_ONE, coef_y: tvbb_pkg::Q16_ZERO,
					       coef_z: tvbb_pkg::Q16_ZERO, offset: tvbb_pkg::Q16_ZERO};
					ry = '{coef_x: tvbb_pkg::Q16_ZERO, coef_y: tvbb_pkg::Q16_ONE,
					       coef_z: tvbb_pkg::Q16_ZERO, offset: tvbb_pkg::Q16_ZERO};
				end else begin
					rx = rand_row();
					ry = rand_row();
				end
				load_matrix(rx, ry);
				sent_here = 0;
				while (sent_here < BlockWords) begin
					len = ($urandom_range(9) == 0) ? $urandom_range(20, 48)
								       : $urandom_range(1, 10);
					send_mesh(len, $urandom_range(14) == 0);
					sent_here += len;
					// Now and then the sender stops until every box word is back.
					if ($urandom_range(19) == 0)
						wait_idle();
				end
			end
		end

		wait_idle();
		if (error_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

`default_nettype wire
